/* rtl/trfs_pkg.sv */
// Shared types and constants for the triangle span generator.
`timescale 1ns / 1ps
package trfs_pkg;

  localparam int COORD_BITS = 12;
  localparam int ACC_W      = 2 * COORD_BITS + 1;
  localparam int CNT_W      = $clog2(ACC_W + 1);
  localparam int COLOR_W    = 16;
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = $clog2(Q_DEPTH);
  localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COORD_BITS:0]   delta_t;
  typedef logic signed [COORD_BITS+1:0] wide_t;
  typedef logic [COORD_BITS-1:0]        height_t;
  typedef logic signed [ACC_W-1:0]      acc_t;
  typedef logic [ACC_W-1:0]             mag_t;
  typedef logic [COORD_BITS:0]          len_t;
  typedef logic [COLOR_W-1:0]           color_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_NEXT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_UPPER = 3'b010,
    PH_LOWER = 3'b100
  } ph_t;

  typedef enum logic [3:0] {
    ST_WAIT  = 4'b0001,
    ST_START = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_EMIT  = 4'b1000
  } st_t;

  typedef struct packed {
    op_t    op;
    logic   flat;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    color_t color;
  } cmd_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    len_t   length;
    color_t color;
    logic   last;
  } span_t;

endpackage

/* rtl/trfs_if.sv */
// Handshake channel interfaces for commands and spans.
`timescale 1ns / 1ps
interface trfs_in_if import trfs_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   opcode;
  coord_t vx_a;
  coord_t vy_a;
  coord_t vx_b;
  coord_t vy_b;
  coord_t vx_c;
  coord_t vy_c;
  color_t fill_color;

  modport source (output valid, opcode, vx_a, vy_a, vx_b, vy_b, vx_c, vy_c, fill_color,
                  input ready);
  modport sink (input valid, opcode, vx_a, vy_a, vx_b, vy_b, vx_c, vy_c, fill_color,
                output ready);
endinterface

interface trfs_out_if import trfs_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t span_x;
  coord_t span_y;
  len_t   span_length;
  color_t span_color;
  logic   span_last;

  modport source (output valid, span_x, span_y, span_length, span_color, span_last,
                  input ready);
  modport sink (input valid, span_x, span_y, span_length, span_color, span_last,
                output ready);
endinterface

/* rtl/trfs_front.sv */
// Command front end: sort vertices by y, flag flat triangles, queue commands.
`timescale 1ns / 1ps
module trfs_front import trfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  trfs_in_if.sink   in_ch,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  logic      cmd_pop
);

  cmd_t              sorted;
  cmd_t              q_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;

  always_comb begin
    coord_t ax, ay, bx, by, cx, cy, tx, ty;
    tx = '0; ty = '0;
    ax = in_ch.vx_a; ay = in_ch.vy_a;
    bx = in_ch.vx_b; by = in_ch.vy_b;
    cx = in_ch.vx_c; cy = in_ch.vy_c;
    if (ay > by) begin
      tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty;
    end
    if (by > cy) begin
      tx = bx; ty = by; bx = cx; by = cy; cx = tx; cy = ty;
    end
    if (ay > by) begin
      tx = ax; ty = ay; ax = bx; ay = by; bx = tx; by = ty;
    end
    sorted.op    = op_t'(in_ch.opcode);
    sorted.flat  = (ay == cy);
    sorted.x0    = ax;
    sorted.y0    = ay;
    sorted.x1    = bx;
    sorted.y1    = by;
    sorted.x2    = cx;
    sorted.y2    = cy;
    sorted.color = in_ch.fill_color;
  end

  assign in_ch.ready = (cnt_r != QCNT_W'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign pop         = cmd_pop && cmd_valid;
  assign cmd         = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = QCNT_W'(cnt_r + QCNT_W'(push) - QCNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= sorted;
    end
  end

endmodule

/* rtl/trfs_div.sv */
// Radix-2 restoring divider: signed accumulator over edge height, truncating.
`timescale 1ns / 1ps
module trfs_div import trfs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  acc_t    num,
  input  height_t den,
  output logic    done,
  output delta_t  quo
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [COORD_BITS-1:0] rem_r, rem_nxt;
  mag_t              q_r, q_nxt;
  height_t           den_r;
  logic              neg_r;
  logic              zero_r;
  logic [COORD_BITS:0] shifted;
  logic              fits;
  delta_t            mag;

  assign shifted = {rem_r, q_r[ACC_W-1]};
  assign fits    = (shifted >= {1'b0, den_r});
  assign mag     = delta_t'(q_r[COORD_BITS:0]);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(ACC_W);
      rem_nxt  = '0;
      q_nxt    = num[ACC_W-1] ? mag_t'(-num) : mag_t'(num);
    end else if (busy_r) begin
      rem_nxt = fits ? COORD_BITS'(shifted - {1'b0, den_r}) : shifted[COORD_BITS-1:0];
      q_nxt   = {q_r[ACC_W-2:0], fits};
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r  <= den;
      neg_r  <= num[ACC_W-1];
      zero_r <= (den == '0);
    end
  end

  assign done = done_r;
  assign quo  = zero_r ? '0 : (neg_r ? delta_t'(-mag) : mag);

endmodule

/* rtl/trfs_engine.sv */
// Span engine: triangle setup, edge interpolation and output register.
`timescale 1ns / 1ps
module trfs_engine import trfs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  input  logic  cmd_valid,
  output logic  cmd_pop,
  output span_t span,
  output logic  span_valid,
  input  logic  span_ready
);

  st_t     st_r, st_nxt;
  ph_t     ph_r, ph_nxt;
  coord_t  row_r, bottom_y_r, top_x_r, mid_x_r;
  delta_t  upper_end_row_r;
  delta_t  dx_tm_r, dx_tb_r, dx_mb_r;
  height_t h_tm_r, h_tb_r, h_mb_r;
  acc_t    short_acc_r, long_acc_r;
  color_t  color_r;
  logic    out_valid_r, out_valid_nxt;
  span_t   out_r;

  logic    slot_free;
  logic    flat_load;
  logic    setup;
  logic    emit;
  logic    div_start;
  logic    short_done, long_done;
  delta_t  short_q, long_q;
  wide_t   a_val, b_val, lo, hi;
  logic    last;
  coord_t  row_inc;
  coord_t  flat_lo, flat_hi;
  span_t   flat_span, tri_span;

  assign slot_free = !out_valid_r || span_ready;
  assign flat_load = (cmd.op == OP_LOAD) && cmd.flat;
  assign cmd_pop   = (st_r == ST_WAIT) && cmd_valid && (!flat_load || slot_free);
  assign setup     = cmd_pop && (cmd.op == OP_LOAD) && !cmd.flat;
  assign div_start = (st_r == ST_START);
  assign emit      = (st_r == ST_EMIT) && slot_free;

  trfs_div u_div_short (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (short_acc_r),
    .den   ((ph_r == PH_UPPER) ? h_tm_r : h_mb_r),
    .done  (short_done),
    .quo   (short_q)
  );

  trfs_div u_div_long (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (long_acc_r),
    .den   (h_tb_r),
    .done  (long_done),
    .quo   (long_q)
  );

  always_comb begin
    flat_lo = cmd.x0;
    flat_hi = cmd.x0;
    if (cmd.x1 < flat_lo) flat_lo = cmd.x1;
    if (cmd.x1 > flat_hi) flat_hi = cmd.x1;
    if (cmd.x2 < flat_lo) flat_lo = cmd.x2;
    if (cmd.x2 > flat_hi) flat_hi = cmd.x2;
    flat_span.x      = flat_lo;
    flat_span.y      = cmd.y0;
    flat_span.length = len_t'(wide_t'(flat_hi) - wide_t'(flat_lo) + wide_t'(1));
    flat_span.color  = cmd.color;
    flat_span.last   = 1'b1;
  end

  always_comb begin
    a_val = ((ph_r == PH_UPPER) ? wide_t'(top_x_r) : wide_t'(mid_x_r)) + wide_t'(short_q);
    b_val = wide_t'(top_x_r) + wide_t'(long_q);
    lo    = (a_val > b_val) ? b_val : a_val;
    hi    = (a_val > b_val) ? a_val : b_val;
    last  = (row_r >= bottom_y_r);
    row_inc = coord_t'(row_r + 1'b1);
    tri_span.x      = coord_t'(lo);
    tri_span.y      = row_r;
    tri_span.length = len_t'(hi - lo + wide_t'(1));
    tri_span.color  = color_r;
    tri_span.last   = last;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_WAIT: begin
        if (cmd_pop) begin
          if (cmd.op == OP_LOAD) begin
            st_nxt = cmd.flat ? ST_WAIT : ST_START;
          end else if (ph_r != PH_IDLE) begin
            st_nxt = ST_START;
          end
        end
      end
      ST_START: st_nxt = ST_DIV;
      ST_DIV: begin
        if (short_done && long_done) st_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) st_nxt = ST_WAIT;
      end
      default: st_nxt = ST_WAIT;
    endcase
  end

  always_comb begin
    ph_nxt = ph_r;
    if (cmd_pop && flat_load) begin
      ph_nxt = PH_IDLE;
    end else if (setup) begin
      ph_nxt = (delta_t'(cmd.y0) <= ((cmd.y1 == cmd.y2) ? delta_t'(cmd.y1)
               : delta_t'(delta_t'(cmd.y1) - delta_t'(1)))) ? PH_UPPER : PH_LOWER;
    end else if (emit) begin
      if (last) begin
        ph_nxt = PH_IDLE;
      end else if (ph_r == PH_UPPER && delta_t'(row_inc) > upper_end_row_r) begin
        ph_nxt = PH_LOWER;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (span_ready) out_valid_nxt = 1'b0;
    if ((cmd_pop && flat_load) || emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_WAIT;
      ph_r        <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && flat_load) begin
      out_r <= flat_span;
    end else if (emit) begin
      out_r <= tri_span;
    end
    if (setup) begin
      top_x_r         <= cmd.x0;
      mid_x_r         <= cmd.x1;
      bottom_y_r      <= cmd.y2;
      dx_tm_r         <= delta_t'(delta_t'(cmd.x1) - delta_t'(cmd.x0));
      dx_tb_r         <= delta_t'(delta_t'(cmd.x2) - delta_t'(cmd.x0));
      dx_mb_r         <= delta_t'(delta_t'(cmd.x2) - delta_t'(cmd.x1));
      h_tm_r          <= height_t'(delta_t'(cmd.y1) - delta_t'(cmd.y0));
      h_tb_r          <= height_t'(delta_t'(cmd.y2) - delta_t'(cmd.y0));
      h_mb_r          <= height_t'(delta_t'(cmd.y2) - delta_t'(cmd.y1));
      upper_end_row_r <= (cmd.y1 == cmd.y2) ? delta_t'(cmd.y1)
                         : delta_t'(delta_t'(cmd.y1) - delta_t'(1));
      row_r           <= cmd.y0;
      short_acc_r     <= '0;
      long_acc_r      <= '0;
      color_r         <= cmd.color;
    end else if (emit && !last) begin
      row_r      <= row_inc;
      long_acc_r <= acc_t'(long_acc_r + acc_t'(dx_tb_r));
      if (ph_r == PH_UPPER && delta_t'(row_inc) > upper_end_row_r) begin
        short_acc_r <= '0;
      end else begin
        short_acc_r <= acc_t'(short_acc_r +
                       acc_t'((ph_r == PH_UPPER) ? dx_tm_r : dx_mb_r));
      end
    end
  end

  assign span       = out_r;
  assign span_valid = out_valid_r;

endmodule

/* rtl/triangle_fill_span_generator.sv */
// Top level of the scanline triangle span generator.
// A span leaves once its command is accepted into an idle engine and has passed
// pop, start, 25 divider steps, done and emit; a flat span is registered at pop.
// Spans are paced by the two parallel 25-step dividers; no new command until emit.
// A two-entry command queue keeps accepting while a span waits at the output.
// Reset (synchronous, active low) empties the queue and returns to idle.
`timescale 1ns / 1ps
module triangle_fill_span_generator import trfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  trfs_in_if.sink    in_ch,
  trfs_out_if.source out_ch
);

  cmd_t  cmd;
  logic  cmd_valid;
  logic  cmd_pop;
  span_t span;

  trfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  trfs_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .span       (span),
    .span_valid (out_ch.valid),
    .span_ready (out_ch.ready)
  );

  assign out_ch.span_x      = span.x;
  assign out_ch.span_y      = span.y;
  assign out_ch.span_length = span.length;
  assign out_ch.span_color  = span.color;
  assign out_ch.span_last   = span.last;

endmodule

/* rtl/trfs_checker.sv */
// Port-level assertions for the triangle span generator, bound to the top level.
`timescale 1ns / 1ps
module trfs_checker import trfs_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   out_valid,
  input logic   out_ready,
  input coord_t span_x,
  input coord_t span_y,
  input len_t   span_length,
  input color_t span_color,
  input logic   span_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("span dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(span_x) && $stable(span_y)
      && $stable(span_length) && $stable(span_color) && $stable(span_last))
    else $error("span changed while stalled");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> span_length != '0)
    else $error("span of zero length");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("span valid after reset");

endmodule

bind triangle_fill_span_generator trfs_checker u_trfs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .span_x      (out_ch.span_x),
  .span_y      (out_ch.span_y),
  .span_length (out_ch.span_length),
  .span_color  (out_ch.span_color),
  .span_last   (out_ch.span_last)
);
